@@ sv/fgr_pkg.sv @@
// ----------------------------------------------------------------------------
// fgr_pkg
// shared types, constants and the microcode program of the fraction reducer
// ----------------------------------------------------------------------------
package fgr_pkg;

   localparam int DEFAULT_DATA_WIDTH = 32;
   localparam int PC_BITS            = 4;

   // datapath action of one control word
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_G_ONE,
      OP_START_AB,
      OP_EUCLID,
      OP_START_N,
      OP_SAVE_N,
      OP_START_D,
      OP_SAVE_D,
      OP_EMIT,
      OP_ZERO
   } op_type;

   // jump condition of one control word
   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_INPUT,
      C_D_ZERO,
      C_NOT_ANY_ZERO,
      C_DIV_BUSY,
      C_REM_NZ,
      C_OUT_FULL
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_BITS-1:0]  target;
   } ctrl_word_type;

   // status flags from the datapath to the sequencer
   typedef struct packed {
      logic req_fire;
      logic d_zero;
      logic any_zero;
      logic div_busy;
      logic rem_nz;
      logic out_full;
   } status_type;

   // program step addresses
   localparam logic [PC_BITS-1:0] S_IDLE    = 4'd0;
   localparam logic [PC_BITS-1:0] S_CHK_D   = 4'd1;
   localparam logic [PC_BITS-1:0] S_CHK_Z   = 4'd2;
   localparam logic [PC_BITS-1:0] S_G_ONE   = 4'd3;
   localparam logic [PC_BITS-1:0] S_EUC     = 4'd4;
   localparam logic [PC_BITS-1:0] S_EUC_W   = 4'd5;
   localparam logic [PC_BITS-1:0] S_EUC_MV  = 4'd6;
   localparam logic [PC_BITS-1:0] S_DIVN    = 4'd7;
   localparam logic [PC_BITS-1:0] S_DIVN_W  = 4'd8;
   localparam logic [PC_BITS-1:0] S_SAVEN   = 4'd9;
   localparam logic [PC_BITS-1:0] S_DIVD    = 4'd10;
   localparam logic [PC_BITS-1:0] S_DIVD_W  = 4'd11;
   localparam logic [PC_BITS-1:0] S_SAVED   = 4'd12;
   localparam logic [PC_BITS-1:0] S_OUT_W   = 4'd13;
   localparam logic [PC_BITS-1:0] S_EMIT    = 4'd14;
   localparam logic [PC_BITS-1:0] S_ZERO    = 4'd15;

   // microcode rom
   function automatic ctrl_word_type ucode_rom(input logic [PC_BITS-1:0] pc);
      ctrl_word_type cw;
      cw = '{op: OP_NONE, cond: C_NEXT, target: S_IDLE};
      unique case (pc)
         S_IDLE:   cw = '{op: OP_LOAD,     cond: C_NO_INPUT,     target: S_IDLE};
         S_CHK_D:  cw = '{op: OP_NONE,     cond: C_D_ZERO,       target: S_ZERO};
         S_CHK_Z:  cw = '{op: OP_NONE,     cond: C_NOT_ANY_ZERO, target: S_EUC};
         S_G_ONE:  cw = '{op: OP_G_ONE,    cond: C_ALWAYS,       target: S_DIVN};
         S_EUC:    cw = '{op: OP_START_AB, cond: C_NEXT,         target: S_IDLE};
         S_EUC_W:  cw = '{op: OP_NONE,     cond: C_DIV_BUSY,     target: S_EUC_W};
         S_EUC_MV: cw = '{op: OP_EUCLID,   cond: C_REM_NZ,       target: S_EUC};
         S_DIVN:   cw = '{op: OP_START_N,  cond: C_NEXT,         target: S_IDLE};
         S_DIVN_W: cw = '{op: OP_NONE,     cond: C_DIV_BUSY,     target: S_DIVN_W};
         S_SAVEN:  cw = '{op: OP_SAVE_N,   cond: C_NEXT,         target: S_IDLE};
         S_DIVD:   cw = '{op: OP_START_D,  cond: C_NEXT,         target: S_IDLE};
         S_DIVD_W: cw = '{op: OP_NONE,     cond: C_DIV_BUSY,     target: S_DIVD_W};
         S_SAVED:  cw = '{op: OP_SAVE_D,   cond: C_NEXT,         target: S_IDLE};
         S_OUT_W:  cw = '{op: OP_NONE,     cond: C_OUT_FULL,     target: S_OUT_W};
         S_EMIT:   cw = '{op: OP_EMIT,     cond: C_ALWAYS,       target: S_IDLE};
         S_ZERO:   cw = '{op: OP_ZERO,     cond: C_ALWAYS,       target: S_OUT_W};
         default:  cw = '{op: OP_NONE,     cond: C_ALWAYS,       target: S_IDLE};
      endcase
      return cw;
   endfunction

endpackage

@@ sv/fgr_div.sv @@
// ----------------------------------------------------------------------------
// fgr_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fgr_div #(
   parameter int DATA_WIDTH = fgr_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  busy,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder
);

   localparam int CNT_BITS = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] dvs_ff, dvs_in;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   trial;

   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DATA_WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // keep the trial difference when it does not go negative
         if (trial[DATA_WIDTH]) begin
            rem_in = shifted[DATA_WIDTH-1:0];
         end else begin
            rem_in = trial[DATA_WIDTH-1:0];
         end
         quo_in = {quo_ff[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/fgr_seq.sv @@
// ----------------------------------------------------------------------------
// fgr_seq
// microcode sequencer: step counter, rom and conditional jumps
// ----------------------------------------------------------------------------
module fgr_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  fgr_pkg::status_type    status,
   output fgr_pkg::ctrl_word_type ctrl
);

   logic [fgr_pkg::PC_BITS-1:0] pc_ff, pc_in;
   fgr_pkg::ctrl_word_type      cw;
   logic                        take;

   assign cw = fgr_pkg::ucode_rom(pc_ff);

   always_comb begin
      unique case (cw.cond)
         fgr_pkg::C_NEXT:         take = 1'b0;
         fgr_pkg::C_ALWAYS:       take = 1'b1;
         fgr_pkg::C_NO_INPUT:     take = ~status.req_fire;
         fgr_pkg::C_D_ZERO:       take = status.d_zero;
         fgr_pkg::C_NOT_ANY_ZERO: take = ~status.any_zero;
         fgr_pkg::C_DIV_BUSY:     take = status.div_busy;
         fgr_pkg::C_REM_NZ:       take = status.rem_nz;
         fgr_pkg::C_OUT_FULL:     take = status.out_full;
         default:                 take = 1'b0;
      endcase
      pc_in = take ? cw.target : pc_ff + fgr_pkg::PC_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= fgr_pkg::S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl = cw;

endmodule

@@ sv/fraction_gcd_reducer_core.sv @@
// ----------------------------------------------------------------------------
// fraction_gcd_reducer_core
// reduces a signed fraction by the euclidean gcd of its magnitudes
// ----------------------------------------------------------------------------
// usage
//   req channel: one transaction carries numerator and denominator, both
//   signed DATA_WIDTH values. rsp channel: one transaction per request with
//   the reduced numerator and denominator.
//   a zero denominator gives 0/1; a zero numerator passes through; when both
//   inputs are negative both results come out positive, otherwise each keeps
//   its own sign.
//   one item is worked at a time. a small microcode program drives a single
//   serial divider, first for the euclid remainder steps and then to divide
//   the numerator and denominator magnitudes by the gcd. the next request
//   is taken once the result has moved to the output register.
//   a stalled rsp side holds the result in the output register; the
//   sequencer then waits before emitting the next one.
//   reset (synchronous, active high) returns the program to the idle step and
//   empties the output register; no other state needs clearing.
// ----------------------------------------------------------------------------
module fraction_gcd_reducer_core #(
   parameter int DATA_WIDTH = fgr_pkg::DEFAULT_DATA_WIDTH,
   localparam int TDATA_WIDTH = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_WIDTH-1:0] req_tdata,   // numerator, denominator, zero pad
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_WIDTH-1:0] rsp_tdata    // reduced_numerator, reduced_denominator, pad
);

   localparam int W = DATA_WIDTH;

   fgr_pkg::ctrl_word_type ctrl;
   fgr_pkg::status_type    status;

   // working registers: a/b hold the euclid pair, n/d the magnitudes
   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] n_ff, n_in;
   logic [W-1:0] d_ff, d_in;
   logic         nneg_ff, nneg_in;
   logic         dneg_ff, dneg_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TDATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   // request fields and magnitudes
   logic [W-1:0] req_num;
   logic [W-1:0] req_den;
   logic [W-1:0] num_mag;
   logic [W-1:0] den_mag;
   logic         req_fire;

   // divider hookup
   logic         div_start;
   logic [W-1:0] div_dividend;
   logic [W-1:0] div_divisor;
   logic         div_busy;
   logic [W-1:0] div_quo;
   logic [W-1:0] div_rem;

   // signed result
   logic [W-1:0] out_num;
   logic [W-1:0] out_den;

   assign req_num  = req_tdata[W-1:0];
   assign req_den  = req_tdata[2*W-1:W];
   // the most negative value negates to itself, which is its magnitude as unsigned
   assign num_mag  = req_num[W-1] ? (~req_num + W'(1)) : req_num;
   assign den_mag  = req_den[W-1] ? (~req_den + W'(1)) : req_den;

   assign req_tready = (ctrl.op == fgr_pkg::OP_LOAD);
   assign req_fire   = req_tvalid & req_tready;

   // status flags for the jump conditions
   always_comb begin
      status.req_fire = req_fire;
      status.d_zero   = (d_ff == '0);
      status.any_zero = (a_ff == '0) | (b_ff == '0);
      status.div_busy = div_busy;
      status.rem_nz   = (div_rem != '0);
      status.out_full = rsp_valid_ff & ~rsp_tready;
   end

   fgr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // divider operand selection per start step
   always_comb begin
      div_start    = 1'b0;
      div_dividend = a_ff;
      div_divisor  = b_ff;
      unique case (ctrl.op)
         fgr_pkg::OP_START_AB: begin
            div_start = 1'b1;
         end
         fgr_pkg::OP_START_N: begin
            div_start    = 1'b1;
            div_dividend = n_ff;
            div_divisor  = a_ff;
         end
         fgr_pkg::OP_START_D: begin
            div_start    = 1'b1;
            div_dividend = d_ff;
            div_divisor  = a_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   fgr_div #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // both negative turns both positive, otherwise each keeps its sign
   assign out_num = (nneg_ff & ~dneg_ff) ? (~n_ff + W'(1)) : n_ff;
   assign out_den = (dneg_ff & ~nneg_ff) ? (~d_ff + W'(1)) : d_ff;

   // datapath actions
   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      nneg_in      = nneg_ff;
      dneg_in      = dneg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (ctrl.op)
         fgr_pkg::OP_LOAD: begin
            if (req_fire) begin
               a_in    = num_mag;
               b_in    = den_mag;
               n_in    = num_mag;
               d_in    = den_mag;
               nneg_in = req_num[W-1];
               dneg_in = req_den[W-1];
            end
         end
         fgr_pkg::OP_G_ONE: begin
            // a zero magnitude makes the divisor one
            a_in = W'(1);
         end
         fgr_pkg::OP_EUCLID: begin
            a_in = b_ff;
            b_in = div_rem;
         end
         fgr_pkg::OP_SAVE_N: begin
            n_in = div_quo;
         end
         fgr_pkg::OP_SAVE_D: begin
            d_in = div_quo;
         end
         fgr_pkg::OP_ZERO: begin
            // zero denominator gives 0/1
            n_in    = '0;
            d_in    = W'(1);
            nneg_in = 1'b0;
            dneg_in = 1'b0;
         end
         fgr_pkg::OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = TDATA_WIDTH'({out_den, out_num});
         end
         default: begin
            a_in = a_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      n_ff        <= n_in;
      d_ff        <= d_in;
      nneg_ff     <= nneg_in;
      dneg_ff     <= dneg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
